/* hdl/dhcprc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhcprc_pkg
// Shared types, constants and byte helpers for the DHCP reply checker.
// ----------------------------------------------------------------------------
package dhcprc_pkg;

  localparam int unsigned MaxMessageBytes = 1024;
  localparam int unsigned NumSlots        = 8;
  localparam int unsigned CfgIdxW         = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgExpectedXid = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgClientMac   = 2'd1;

  // header values
  localparam logic [7:0] OpReply = 8'd2;
  localparam logic [7:0] Cookie0 = 8'h63;
  localparam logic [7:0] Cookie1 = 8'h82;
  localparam logic [7:0] Cookie2 = 8'h53;
  localparam logic [7:0] Cookie3 = 8'h63;

  // option codes
  localparam logic [7:0] OptPad    = 8'd0;
  localparam logic [7:0] OptMask   = 8'd1;
  localparam logic [7:0] OptRouter = 8'd3;
  localparam logic [7:0] OptDns    = 8'd6;
  localparam logic [7:0] OptLease  = 8'd51;
  localparam logic [7:0] OptServer = 8'd54;
  localparam logic [7:0] OptRenew  = 8'd58;
  localparam logic [7:0] OptEnd    = 8'hff;

  // lease slots
  localparam int unsigned SlotClient = 0;
  localparam int unsigned SlotMask   = 1;
  localparam int unsigned SlotRouter = 2;
  localparam int unsigned SlotDns1   = 3;
  localparam int unsigned SlotDns2   = 4;
  localparam int unsigned SlotServer = 5;
  localparam int unsigned SlotLease  = 6;
  localparam int unsigned SlotRenew  = 7;

  typedef logic [NumSlots-1:0][31:0] lease_t;

  typedef enum logic [2:0] {
    PhCode  = 3'b001,
    PhLen   = 3'b010,
    PhValue = 3'b100
  } opt_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic   packet_ok;
    lease_t lease;
  } result_t;

  // byte k of a big-endian 32-bit word, k = 0 is bits 31..24
  function automatic logic [7:0] word_byte(logic [31:0] w, logic [1:0] k);
    logic [31:0] s;
    s = w >> {2'd3 - k, 3'b000};
    return s[7:0];
  endfunction

  // byte j (0..5) of a big-endian 48-bit address
  function automatic logic [7:0] mac_byte(logic [47:0] m, logic [2:0] j);
    logic [47:0] s;
    s = m >> {3'd5 - j, 3'b000};
    return s[7:0];
  endfunction

  // left-justified capture of value byte pos
  function automatic logic [31:0] put_byte(logic [31:0] w, logic [7:0] pos,
                                           logic [7:0] b);
    logic [31:0] r;
    r = w;
    if (pos == 8'd0) begin
      r = {b, 24'b0};
    end else if (pos < 8'd4) begin
      r = w | ({24'b0, b} << {2'd3 - pos[1:0], 3'b000});
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/dhcprc_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhcprc_in_stage
// Input register: holds one byte item until the parser stage takes it.
// ----------------------------------------------------------------------------
module dhcprc_in_stage (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire dhcprc_pkg::byte_item_t  item_i,
  output logic                         valid_o,
  input  wire logic                    take_i,
  output dhcprc_pkg::byte_item_t       item_o
);
  import dhcprc_pkg::*;

  logic       valid_q, valid_d;
  byte_item_t item_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

/* hdl/dhcprc_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhcprc_parser
// Per-byte header check and option walk; keeps working and kept leases.
// ----------------------------------------------------------------------------
module dhcprc_parser #(
  parameter int unsigned MAX_MESSAGE_BYTES = dhcprc_pkg::MaxMessageBytes
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,
  input  wire dhcprc_pkg::byte_item_t  item_i,
  input  wire logic [31:0]             expected_xid_i,
  input  wire logic [47:0]             client_mac_i,
  output dhcprc_pkg::result_t          result_o
);
  import dhcprc_pkg::*;

  localparam int unsigned OffW = $clog2(MAX_MESSAGE_BYTES + 1);

  logic [OffW-1:0] offset_q, offset_d;
  logic            match_q, match_d;
  opt_phase_e      phase_q, phase_d;
  logic [7:0]      code_q, code_d;
  logic [7:0]      remain_q, remain_d;
  logic [7:0]      index_q, index_d;
  logic            ended_q, ended_d;
  lease_t          work_q, work_d;
  lease_t          kept_q, kept_d;
  logic            ok;
  logic [7:0]      b;
  logic [8:0]      opt_len;
  logic [7:0]      rem_dec;

  always_comb begin
    offset_d = offset_q;
    match_d  = match_q;
    phase_d  = phase_q;
    code_d   = code_q;
    remain_d = remain_q;
    index_d  = index_q;
    ended_d  = ended_q;
    work_d   = work_q;
    kept_d   = kept_q;
    ok       = 1'b0;
    b        = item_i.data;
    opt_len  = {1'b0, remain_q} + {1'b0, index_q};
    rem_dec  = remain_q - 8'd1;

    if (step_i) begin
      if (offset_q < OffW'(MAX_MESSAGE_BYTES)) begin
        offset_d = offset_q + OffW'(1);
        if (offset_q == '0) begin
          work_d = kept_q;
          if (b != OpReply) match_d = 1'b0;
        end else if (offset_q >= OffW'(4) && offset_q <= OffW'(7)) begin
          if (word_byte(expected_xid_i, offset_q[1:0]) != b) match_d = 1'b0;
        end else if (offset_q >= OffW'(16) && offset_q <= OffW'(19)) begin
          work_d[SlotClient] = put_byte(work_q[SlotClient], {6'b0, offset_q[1:0]}, b);
        end else if (offset_q >= OffW'(28) && offset_q <= OffW'(33)) begin
          if (mac_byte(client_mac_i, 3'(offset_q - OffW'(28))) != b) match_d = 1'b0;
        end else if (offset_q >= OffW'(236) && offset_q <= OffW'(239)) begin
          case (offset_q[1:0])
            2'd0:    if (b != Cookie0) match_d = 1'b0;
            2'd1:    if (b != Cookie1) match_d = 1'b0;
            2'd2:    if (b != Cookie2) match_d = 1'b0;
            default: if (b != Cookie3) match_d = 1'b0;
          endcase
        end else if (offset_q >= OffW'(240) && !ended_q) begin
          case (phase_q)
            PhCode: begin
              if (b == OptEnd) begin
                ended_d = 1'b1;
              end else if (b != OptPad) begin
                code_d  = b;
                phase_d = PhLen;
              end
            end
            PhLen: begin
              remain_d = b;
              index_d  = 8'd0;
              if (code_q == OptDns) work_d[SlotDns2] = '0;
              phase_d = (b == 8'd0) ? PhCode : PhValue;
            end
            PhValue: begin
              case (code_q)
                OptMask:   work_d[SlotMask]   = put_byte(work_q[SlotMask], index_q, b);
                OptRouter: work_d[SlotRouter] = put_byte(work_q[SlotRouter], index_q, b);
                OptDns: begin
                  if (index_q < 8'd4) begin
                    work_d[SlotDns1] = put_byte(work_q[SlotDns1], index_q, b);
                  end else if (opt_len == 9'd8 && index_q < 8'd8) begin
                    work_d[SlotDns2] = put_byte(work_q[SlotDns2], index_q - 8'd4, b);
                  end
                end
                OptLease:  work_d[SlotLease]  = put_byte(work_q[SlotLease], index_q, b);
                OptServer: work_d[SlotServer] = put_byte(work_q[SlotServer], index_q, b);
                OptRenew:  work_d[SlotRenew]  = put_byte(work_q[SlotRenew], index_q, b);
                default: ;
              endcase
              index_d  = index_q + 8'd1;
              remain_d = rem_dec;
              if (rem_dec == 8'd0) phase_d = PhCode;
            end
            default: phase_d = PhCode;
          endcase
        end
      end

      if (item_i.last) begin
        ok = match_d && (offset_q >= OffW'(239));
        if (ok) begin
          kept_d = work_d;
          if (work_d[SlotRenew] == '0) kept_d[SlotRenew] = {1'b0, work_d[SlotLease][31:1]};
        end
        offset_d = '0;
        match_d  = 1'b1;
        phase_d  = PhCode;
        code_d   = 8'd0;
        remain_d = 8'd0;
        index_d  = 8'd0;
        ended_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      match_q  <= 1'b1;
      phase_q  <= PhCode;
      code_q   <= 8'd0;
      remain_q <= 8'd0;
      index_q  <= 8'd0;
      ended_q  <= 1'b0;
      work_q   <= '0;
      kept_q   <= '0;
    end else begin
      offset_q <= offset_d;
      match_q  <= match_d;
      phase_q  <= phase_d;
      code_q   <= code_d;
      remain_q <= remain_d;
      index_q  <= index_d;
      ended_q  <= ended_d;
      work_q   <= work_d;
      kept_q   <= kept_d;
    end
  end

  assign result_o.packet_ok = ok;
  assign result_o.lease     = kept_d;

endmodule
`default_nettype wire

/* hdl/dhcp_reply_check_and_option_parse_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhcp_reply_check_and_option_parse_top
// DHCP reply checker and option parser, one message byte per item.
// ----------------------------------------------------------------------------
// A DHCP reply is streamed in one byte per item from offset zero, with
// last_byte_i marking its final byte. The op code, transaction id, client
// hardware address and magic cookie are checked as they pass; from offset 240
// the option list is walked to the end option and the offered address, mask,
// router, one or two DNS servers, server id, lease and renewal times are
// captured. Each last-byte item yields exactly one result item: packet_ok_o
// and the kept lease, which is replaced only when every check passed (a zero
// renewal time then becomes half the lease time). Options missing from a good
// reply keep their earlier values. Rate: one item per clock, sustained; the
// block takes a new byte every cycle while out_ready_i is high or the result
// register is empty. From input acceptance to result valid, an item passes
// the input register, then the parser into the result register. Bytes at
// or beyond MAX_MESSAGE_BYTES are ignored. Configuration is written through
// the cfg channel, always ready; the user must write it only while no
// message is in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module dhcp_reply_check_and_option_parse_top #(
  parameter int unsigned MAX_MESSAGE_BYTES = dhcprc_pkg::MaxMessageBytes
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [dhcprc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [47:0]                      cfg_data_i,
  // byte items in
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [7:0]                       data_byte_i,
  input  wire logic                             last_byte_i,
  // result items out
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  packet_ok_o,
  output logic [31:0]                           offered_addr_o,
  output logic [31:0]                           subnet_mask_o,
  output logic [31:0]                           gateway_addr_o,
  output logic [31:0]                           dns_primary_o,
  output logic [31:0]                           dns_secondary_o,
  output logic [31:0]                           server_id_o,
  output logic [31:0]                           lease_seconds_o,
  output logic [31:0]                           renew_seconds_o
);
  import dhcprc_pkg::*;

  // configuration registers
  logic [31:0] xid_q;
  logic [47:0] mac_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xid_q <= '0;
      mac_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgExpectedXid: xid_q <= cfg_data_i[31:0];
        CfgClientMac:   mac_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  byte_item_t in_item, s1_item;
  logic       s1_valid;
  logic       advance;

  // result register state
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  logic    load;

  assign in_item.data = data_byte_i;
  assign in_item.last = last_byte_i;

  // the parser stage moves whenever the result register can take a result
  assign advance = s1_valid && (!out_valid_q || out_ready_i);

  dhcprc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .valid_o (s1_valid),
    .take_i  (advance),
    .item_o  (s1_item)
  );

  // parser
  result_t result;

  dhcprc_parser #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .item_i         (s1_item),
    .expected_xid_i (xid_q),
    .client_mac_i   (mac_q),
    .result_o       (result)
  );

  // result register: loaded only on a last-byte item
  assign load = advance && s1_item.last;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign packet_ok_o     = out_q.packet_ok;
  assign offered_addr_o  = out_q.lease[SlotClient];
  assign subnet_mask_o   = out_q.lease[SlotMask];
  assign gateway_addr_o  = out_q.lease[SlotRouter];
  assign dns_primary_o   = out_q.lease[SlotDns1];
  assign dns_secondary_o = out_q.lease[SlotDns2];
  assign server_id_o     = out_q.lease[SlotServer];
  assign lease_seconds_o = out_q.lease[SlotLease];
  assign renew_seconds_o = out_q.lease[SlotRenew];

endmodule
`default_nettype wire

/* verif/tb_lease_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lease_pkg
// Lease tracker for the DHCP reply checker bench: follows each accepted byte
// item, predicts the reply item due on a last byte and checks what arrives.
// ----------------------------------------------------------------------------
package tb_lease_pkg;
  import dhcprc_pkg::*;

  class lease_tracker;
    logic [31:0] xid;
    logic [47:0] mac;
    int unsigned offset;
    bit          hdr_ok;
    opt_phase_e  phase;
    logic [7:0]  code;
    logic [7:0]  remain;
    logic [7:0]  idx;
    bit          ended;
    lease_t      work;
    lease_t      kept;
    result_t     replies_due[$];
    int unsigned errors;
    string       field_names[NumSlots];

    function new();
      field_names = '{"offered_addr", "subnet_mask", "gateway_addr", "dns_primary",
                      "dns_secondary", "server_id", "lease_seconds",
                      "renew_seconds"};
      xid    = '0;
      mac    = '0;
      work   = '0;
      kept   = '0;
      errors = 0;
      restart();
    endfunction

    // per-message state back to its idle values
    function void restart();
      offset = 0;
      hdr_ok = 1'b1;
      phase  = PhCode;
      code   = '0;
      remain = '0;
      idx    = '0;
      ended  = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] index, logic [47:0] value);
      case (index)
        CfgExpectedXid: xid = value[31:0];
        CfgClientMac:   mac = value;
        default: ;
      endcase
    endfunction

    // value bytes are left-justified; bytes past the fourth are dropped
    function void capture(int unsigned slot, logic [7:0] pos, logic [7:0] b);
      if (pos == 8'd0) begin
        work[slot] = {b, 24'h0};
      end else if (pos < 8'd4) begin
        work[slot] = work[slot] | ({24'h0, b} << (8 * (3 - pos)));
      end
    endfunction

    function void option_byte(logic [7:0] b);
      int unsigned full_len;
      if (ended) return;
      case (phase)
        PhCode: begin
          if (b == OptEnd) begin
            ended = 1'b1;
          end else if (b != OptPad) begin
            code  = b;
            phase = PhLen;
          end
        end
        PhLen: begin
          remain = b;
          idx    = '0;
          if (code == OptDns) work[SlotDns2] = '0;
          phase = (b == 8'd0) ? PhCode : PhValue;
        end
        default: begin
          full_len = int'(remain) + int'(idx);
          case (code)
            OptMask:   capture(SlotMask, idx, b);
            OptRouter: capture(SlotRouter, idx, b);
            OptDns: begin
              if (idx < 8'd4) begin
                capture(SlotDns1, idx, b);
              end else if (full_len == 8 && idx < 8'd8) begin
                capture(SlotDns2, idx - 8'd4, b);
              end
            end
            OptLease:  capture(SlotLease, idx, b);
            OptServer: capture(SlotServer, idx, b);
            OptRenew:  capture(SlotRenew, idx, b);
            default: ;
          endcase
          idx    = idx + 8'd1;
          remain = remain - 8'd1;
          if (remain == 8'd0) phase = PhCode;
        end
      endcase
    endfunction

    function void header_byte(int unsigned off, logic [7:0] b);
      logic [31:0] magic;
      logic [47:0] sh;
      magic = {Cookie0, Cookie1, Cookie2, Cookie3};
      if (off == 0) begin
        work = kept;
        if (b != OpReply) hdr_ok = 1'b0;
      end else if (off >= 4 && off <= 7) begin
        sh = {16'h0, xid} >> (8 * (7 - off));
        if (sh[7:0] != b) hdr_ok = 1'b0;
      end else if (off >= 16 && off <= 19) begin
        capture(SlotClient, 8'(off - 16), b);
      end else if (off >= 28 && off <= 33) begin
        sh = mac >> (8 * (33 - off));
        if (sh[7:0] != b) hdr_ok = 1'b0;
      end else if (off >= 236 && off <= 239) begin
        sh = {16'h0, magic} >> (8 * (239 - off));
        if (sh[7:0] != b) hdr_ok = 1'b0;
      end else if (off >= 240) begin
        option_byte(b);
      end
    endfunction

    // one accepted byte item; queues a reply when it closes a message
    function void note_byte(logic [7:0] b, logic last);
      int unsigned off;
      result_t     r;
      off = offset;
      if (off < MaxMessageBytes) begin
        header_byte(off, b);
        offset = off + 1;
      end
      if (!last) return;
      r.packet_ok = hdr_ok && off >= 239;
      if (r.packet_ok) begin
        kept = work;
        if (kept[SlotRenew] == '0) kept[SlotRenew] = kept[SlotLease] >> 1;
      end
      r.lease = kept;
      replies_due.push_back(r);
      restart();
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (replies_due.size() == 0) begin
        $error("reply item with none expected");
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (got.packet_ok !== want.packet_ok) begin
        $error("packet_ok: expected %0b, got %0b", want.packet_ok, got.packet_ok);
        errors++;
      end
      for (int s = 0; s < NumSlots; s++) begin
        if (got.lease[s] !== want.lease[s]) begin
          $error("%s: expected %h, got %h", field_names[s], want.lease[s],
                 got.lease[s]);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction
  endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the DHCP reply checker: streams replies byte by byte and checks
// every reply item against an in-bench lease tracker.
// ----------------------------------------------------------------------------
// Flow: reset, configure, a directed set of replies (short, header-only,
// each header check broken, short/long/zero-length options, DNS with 4, 8 and
// 12 bytes, zero renewal, truncated option, over-long message, maximum option
// length), then random phases. Each phase rewrites xid and MAC (all-zero and
// all-one settings included) while the block is idle, and picks an idling
// mode for sender and receiver. Now and then the receiver holds off for a
// long stretch while short messages keep coming, so the input backs up.
// ----------------------------------------------------------------------------
module tb_top;
  import dhcprc_pkg::*;
  import tb_lease_pkg::*;

  localparam int unsigned CycleLimit    = 600_000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned RandomItems   = 1000;
  localparam int unsigned MinPhases     = 4;
  localparam logic [7:0]  OptDomain     = 8'd15;  // skipped by the parser

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [47:0]         cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [7:0]          data_byte_i = '0;
  logic                last_byte_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                packet_ok_o;
  logic [31:0]         offered_addr_o;
  logic [31:0]         subnet_mask_o;
  logic [31:0]         gateway_addr_o;
  logic [31:0]         dns_primary_o;
  logic [31:0]         dns_secondary_o;
  logic [31:0]         server_id_o;
  logic [31:0]         lease_seconds_o;
  logic [31:0]         renew_seconds_o;

  lease_tracker tracker = new();

  // message under construction, and the settings it is built against
  logic [7:0]  msg[$];
  logic [31:0] cur_xid = '0;
  logic [47:0] cur_mac = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stall_asks     = 0;   // bumped by stimulus to ask for a hold-off
  int unsigned stall_seen     = 0;
  int unsigned hold_left      = 0;
  int unsigned bytes_sent     = 0;
  int unsigned cycle_count    = 0;

  dhcp_reply_check_and_option_parse_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .packet_ok_o     (packet_ok_o),
    .offered_addr_o  (offered_addr_o),
    .subnet_mask_o   (subnet_mask_o),
    .gateway_addr_o  (gateway_addr_o),
    .dns_primary_o   (dns_primary_o),
    .dns_secondary_o (dns_secondary_o),
    .server_id_o     (server_id_o),
    .lease_seconds_o (lease_seconds_o),
    .renew_seconds_o (renew_seconds_o)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Receiver: checks each accepted reply item, then decides ready for the
  // next cycle. A hold-off request from the stimulus forces ready low for a
  // long stretch, counted here.
  always @(posedge clk_i) begin : collect_replies
    result_t reply;
    if (rst_ni && out_valid_o && out_ready_i) begin
      reply.packet_ok         = packet_ok_o;
      reply.lease[SlotClient] = offered_addr_o;
      reply.lease[SlotMask]   = subnet_mask_o;
      reply.lease[SlotRouter] = gateway_addr_o;
      reply.lease[SlotDns1]   = dns_primary_o;
      reply.lease[SlotDns2]   = dns_secondary_o;
      reply.lease[SlotServer] = server_id_o;
      reply.lease[SlotLease]  = lease_seconds_o;
      reply.lease[SlotRenew]  = renew_seconds_o;
      tracker.check_reply(reply);
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (stall_seen != stall_asks) begin
      stall_seen  <= stall_asks;
      hold_left   <= HoldOffCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Driving. All tasks are entered at a rising edge and leave at one.
  // --------------------------------------------------------------------------

  // one byte item; the sender may idle first, valid then stays high
  task automatic send_byte(input logic [7:0] b, input logic l);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_byte(b, l);
    bytes_sent++;
  endtask

  task automatic send_message();
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // wait until every reply is in, then let the two-stage pipe empty
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // config only while idle; valid is lowered once, after both writes
  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [47:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.write_reg(index, value);
  endtask

  task automatic set_config(input logic [31:0] xid, input logic [47:0] mac);
    write_reg(CfgExpectedXid, {16'h0, xid});
    write_reg(CfgClientMac, mac);
    cfg_valid_i <= 1'b0;
    cur_xid = xid;
    cur_mac = mac;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct   = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // --------------------------------------------------------------------------
  // Message building
  // --------------------------------------------------------------------------

  // 240-byte header that passes every check; the rest is random
  function automatic void build_header();
    logic [31:0] magic;
    magic = {Cookie0, Cookie1, Cookie2, Cookie3};
    msg.delete();
    for (int i = 0; i < 240; i++) msg.push_back(8'($urandom));
    msg[0] = OpReply;
    for (int k = 0; k < 4; k++) begin
      msg[4 + k]   = 8'(cur_xid >> (8 * (3 - k)));
      msg[236 + k] = 8'(magic >> (8 * (3 - k)));
    end
    for (int j = 0; j < 6; j++) msg[28 + j] = 8'(cur_mac >> (8 * (5 - j)));
  endfunction

  function automatic void add_opt(input logic [7:0] code, input int unsigned len,
                                  input bit zero_fill);
    msg.push_back(code);
    msg.push_back(8'(len));
    repeat (len) msg.push_back(zero_fill ? 8'h00 : 8'($urandom));
  endfunction

  function automatic void add_word_opt(input logic [7:0] code, input logic [31:0] w);
    msg.push_back(code);
    msg.push_back(8'd4);
    for (int k = 0; k < 4; k++) msg.push_back(8'(w >> (8 * (3 - k))));
  endfunction

  // break one header check: op, an xid byte, a MAC byte or a cookie byte
  function automatic void corrupt_field(input int unsigned which);
    int unsigned off;
    case (which)
      0:       off = 0;
      1:       off = 4 + $urandom_range(3);
      2:       off = 28 + $urandom_range(5);
      default: off = 236 + $urandom_range(3);
    endcase
    msg[off] = msg[off] ^ 8'($urandom_range(255, 1));
  endfunction

  function automatic void add_random_options();
    int unsigned len;
    logic [7:0]  code;
    repeat ($urandom_range(7)) begin
      case ($urandom_range(8))
        0:       code = OptPad;
        1:       code = OptMask;
        2:       code = OptRouter;
        3:       code = OptDns;
        4:       code = OptLease;
        5:       code = OptServer;
        6:       code = OptRenew;
        7:       code = OptDomain;
        default: code = 8'($urandom_range(254, 1));
      endcase
      if (code == OptPad) begin
        msg.push_back(OptPad);
      end else begin
        len = 4;
        if (code == OptDns && $urandom_range(1) == 1) len = 8;
        if ($urandom_range(4) == 0) len = $urandom_range(10);
        if ($urandom_range(39) == 0) len = $urandom_range(255);
        // a zero renewal gets replaced by half the lease
        add_opt(code, len, code == OptRenew && $urandom_range(9) < 4);
      end
    end
    if ($urandom_range(4) != 0) begin
      msg.push_back(OptEnd);
      repeat ($urandom_range(4)) msg.push_back(8'($urandom));
    end
  endfunction

  // mostly well-formed replies with random content, the rest broken or noise
  function automatic void make_random_message();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 98) begin
      build_header();
      add_random_options();
    end
    if (pick >= 65 && pick < 78) begin
      corrupt_field($urandom_range(3));
    end else if (pick >= 78 && pick < 88) begin
      msg.delete();
      repeat ($urandom_range(40, 1)) msg.push_back(8'($urandom));
    end else if (pick >= 88 && pick < 98) begin
      // cut short, possibly inside the header or an option
      while (msg.size() > $urandom_range(msg.size(), 180)) void'(msg.pop_back());
    end else if (pick >= 98) begin
      // over-long: the tail past the size limit is ignored
      build_header();
      repeat ($urandom_range(790, 770)) msg.push_back(OptPad);
      add_random_options();
      repeat ($urandom_range(20)) msg.push_back(8'($urandom));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase_no;
    int unsigned rand_start;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(32'h3903_F326, 48'h0200_5E10_2030);

    // lone byte closing a message at offset zero: checks fail, nothing kept
    msg.delete();
    msg.push_back(8'h00);
    send_message();

    // full reply: pad, long router value, two DNS servers, skipped options,
    // zero renewal, bytes after the end option
    build_header();
    msg.push_back(OptPad);
    add_word_opt(OptMask, 32'hFFFF_FF00);
    add_opt(OptRouter, 8, 1'b0);
    add_opt(OptDns, 8, 1'b0);
    add_word_opt(OptServer, 32'hC0A8_0101);
    add_word_opt(OptLease, 32'h0001_5181);
    add_word_opt(OptRenew, 32'h0000_0000);
    add_opt(OptDomain, 5, 1'b0);
    add_opt(8'h52, 3, 1'b0);
    msg.push_back(OptEnd);
    add_word_opt(OptLease, 32'hFFFF_FFFF);
    send_message();

    // header only, last byte at the final cookie byte: passes, options kept
    build_header();
    send_message();

    // one byte short of the cookie: fails
    build_header();
    void'(msg.pop_back());
    send_message();

    // each header check broken on its own
    for (int w = 0; w < 4; w++) begin
      build_header();
      add_word_opt(OptLease, 32'h0BAD_0BAD);
      msg.push_back(OptEnd);
      corrupt_field(w);
      send_message();
    end

    // short, zero-length and long values; DNS with 8, 4 and 12 bytes
    build_header();
    add_opt(OptDns, 8, 1'b0);
    add_opt(OptDns, 4, 1'b0);
    add_opt(OptMask, 2, 1'b0);
    add_opt(OptRouter, 0, 1'b0);
    add_opt(OptLease, 6, 1'b0);
    add_opt(OptDns, 12, 1'b0);
    add_word_opt(OptRenew, 32'h0000_0E10);
    msg.push_back(OptEnd);
    send_message();

    // DNS with 8 bytes again, then lease option cut off after two value bytes
    build_header();
    add_opt(OptDns, 8, 1'b0);
    msg.push_back(OptLease);
    msg.push_back(8'd4);
    msg.push_back(8'h12);
    msg.push_back(8'h34);
    send_message();

    // lease option straddling the size limit, end option beyond it
    build_header();
    repeat (1020 - 240) msg.push_back(OptPad);
    add_word_opt(OptLease, 32'h0A0B_0C0D);
    msg.push_back(OptEnd);
    repeat (8) msg.push_back(8'hFF);
    send_message();

    // largest option length, all-ones server id
    build_header();
    add_opt(OptDomain, 255, 1'b0);
    add_word_opt(OptServer, 32'hFFFF_FFFF);
    msg.push_back(OptEnd);
    send_message();

    drain();

    // random phases, one per idling mode at least; settings change only
    // between them, once drained
    phase_no   = 0;
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RandomItems || phase_no < MinPhases) begin
      case (phase_no % 6)
        0:       set_config('0, '0);
        1:       set_config('1, '1);
        default: set_config($urandom, 48'({$urandom, $urandom}));
      endcase
      case (phase_no % 4)
        0:       set_idling(0, 0);
        1:       set_idling(62, 0);
        2:       set_idling(0, 62);
        default: set_idling(21, 21);
      endcase
      @(posedge clk_i);

      // hold the receiver off while short messages keep coming
      if (phase_no % 5 == 2) begin
        stall_asks <= stall_asks + 1;
        repeat (16) begin
          msg.delete();
          repeat ($urandom_range(4, 1)) msg.push_back(8'($urandom));
          send_message();
        end
      end

      make_random_message();
      send_message();
      drain();
      phase_no++;
    end

    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
